[sv/obl_pkg.sv]
// obl_pkg: shared types, codes and helpers for the ordered byte list engine
// no dependencies; imported by every module of the block

package obl_pkg;

	// widths of the item fields
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_MERGE  = 2'd2;
	localparam logic [1:0] FN_NOP    = 2'd3;

	// result status codes
	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_MISSING = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

	// ascii letter bounds
	localparam byte_t CH_UA = 8'h41;
	localparam byte_t CH_UZ = 8'h5A;
	localparam byte_t CH_LA = 8'h61;
	localparam byte_t CH_LZ = 8'h7A;
	localparam byte_t CASE_OFFSET = 8'h20;

	// operation that a row of cells applies to its entries
	typedef enum logic [1:0] {
		ROW_HOLD,
		ROW_INSERT,
		ROW_DELETE,
		ROW_ROTATE
	} row_op_t;

	typedef struct packed {
		row_op_t op;
		byte_t   key;
	} row_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_MERGE
	} obl_state_t;

	function automatic logic is_letter(input byte_t c);
		is_letter = ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
	endfunction

	function automatic byte_t to_upper(input byte_t c);
		if ((c >= CH_LA) && (c <= CH_LZ)) begin
			to_upper = c - CASE_OFFSET;
		end else begin
			to_upper = c;
		end
	endfunction

endpackage

[sv/obl_cell.sv]
// obl_cell: one entry of a sorted table, with its compare and shift logic
// depends on obl_pkg

module obl_cell (
	input  logic             clk,
	input  obl_pkg::row_ctl_t ctl,
	input  logic             occ,
	input  logic             last,
	input  logic             left_mark,
	input  obl_pkg::byte_t   left_data,
	input  obl_pkg::byte_t   right_data,
	input  obl_pkg::byte_t   head_data,
	output obl_pkg::byte_t   data,
	output logic             mark,
	output logic             hit
);
	import obl_pkg::*;

	byte_t data_q;
	byte_t data_d;

	// at or past the key position: empty, or entry not below the key
	assign mark = !occ || (data_q >= ctl.key);
	// this is the first entry not below the key, and it equals the key
	assign hit  = mark && !left_mark && occ && (data_q == ctl.key);
	assign data = data_q;

	// next entry value
	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			ROW_HOLD: begin
				data_d = data_q;
			end
			ROW_INSERT: begin
				if (mark) begin
					data_d = left_mark ? left_data : ctl.key;
				end
			end
			ROW_DELETE: begin
				if (mark) begin
					data_d = right_data;
				end
			end
			ROW_ROTATE: begin
				if (occ) begin
					data_d = last ? head_data : right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// entry storage
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

[sv/obl_row.sv]
// obl_row: one sorted table built as a row of obl_cell entries
// depends on obl_pkg and obl_cell

module obl_row #(
	parameter  int CAPACITY = 16,
	localparam int FILL_W   = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  obl_pkg::row_ctl_t ctl,
	input  logic [FILL_W-1:0] fill,
	output obl_pkg::byte_t    head,
	output logic              found
);
	import obl_pkg::*;

	byte_t               cell_data [CAPACITY];
	logic [CAPACITY-1:0] marks;
	logic [CAPACITY-1:0] hits;

	// row of cells, each wired to its neighbours (the end cells to themselves)
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic  occ;
		logic  last;
		logic  lmark;
		byte_t ldata;
		byte_t rdata;

		assign occ  = FILL_W'(i) < fill;
		assign last = FILL_W'(i + 1) == fill;

		if (i == 0) begin : g_first
			assign lmark = 1'b0;
			assign ldata = cell_data[0];
		end else begin : g_inner
			assign lmark = marks[i-1];
			assign ldata = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign rdata = cell_data[i];
		end else begin : g_mid
			assign rdata = cell_data[i+1];
		end

		obl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ),
			.last       (last),
			.left_mark  (lmark),
			.left_data  (ldata),
			.right_data (rdata),
			.head_data  (cell_data[0]),
			.data       (cell_data[i]),
			.mark       (marks[i]),
			.hit        (hits[i])
		);
	end

	// smallest entry and match flag
	assign head  = cell_data[0];
	assign found = |hits;

endmodule

[sv/ordered_byte_list_engine.sv]
// ordered_byte_list_engine: two sorted byte tables with insert, delete and merge
// depends on obl_pkg and obl_row
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, list_sel and value.
//   Output channel (out_valid/out_ready) carries status and fill_count, one
//   item per input item, in order.
//   Insert, delete and the unused code take effect in the cycle they are
//   accepted; the result is shown on the next cycle. A new item may follow
//   every cycle while the output register drains.
//   Merge walks table B through the cell rows, one entry per cycle, and
//   in_ready stays low meanwhile; the result appears after the last step.
//   A merge with B empty answers at once like an insert. B is rotated back
//   to its original order by the end.
//   One output register sits between the sides: in_ready falls while a
//   result is held by a stalled receiver, nothing is dropped.
//   Reset empties both tables (fill counts to zero) and clears out_valid;
//   the tables themselves are not swept.

module ordered_byte_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic       list_sel,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [4:0] fill_count
);
	import obl_pkg::*;

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);
	localparam logic [FILL_W-1:0] ONE_FILL = FILL_W'(1);

	obl_state_t state_q, state_d;
	logic [FILL_W-1:0] fill_a_q, fill_a_d;
	logic [FILL_W-1:0] fill_b_q, fill_b_d;
	logic [FILL_W-1:0] rem_q, rem_d;
	logic              mfull_q, mfull_d;
	logic              out_valid_q;
	status_t           status_q;
	logic [COUNT_W-1:0] fill_count_q;

	row_ctl_t ctl_a, ctl_b;
	byte_t    head_a, head_b;
	logic     found_a, found_b;

	logic              accept;
	logic              out_load;
	status_t           st_res;
	logic [FILL_W-1:0] cnt_res;
	logic [31:0]       cnt_ext;
	logic [FILL_W-1:0] sel_fill;
	byte_t             sel_head;
	logic              sel_found;
	byte_t             ins_key;
	byte_t             del_key;
	byte_t             idle_key;
	logic              full_now;

	// the two tables
	obl_row #(.CAPACITY(CAPACITY)) u_row_a (
		.clk   (clk),
		.ctl   (ctl_a),
		.fill  (fill_a_q),
		.head  (head_a),
		.found (found_a)
	);

	obl_row #(.CAPACITY(CAPACITY)) u_row_b (
		.clk   (clk),
		.ctl   (ctl_b),
		.fill  (fill_b_q),
		.head  (head_b),
		.found (found_b)
	);

	// handshake
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// selected table and key folding
	assign sel_fill  = list_sel ? fill_b_q : fill_a_q;
	assign sel_head  = list_sel ? head_b : head_a;
	assign sel_found = list_sel ? found_b : found_a;
	assign ins_key   = to_upper(value);
	assign del_key   = (is_letter(value) && is_letter(sel_head)) ? to_upper(value) : value;
	assign idle_key  = (func == FN_DELETE) ? del_key : ins_key;
	assign full_now  = fill_a_q == CAP_FILL;

	// next state, row commands and result
	always_comb begin
		state_d  = state_q;
		fill_a_d = fill_a_q;
		fill_b_d = fill_b_q;
		rem_d    = rem_q;
		mfull_d  = mfull_q;
		out_load = 1'b0;
		st_res   = ST_DONE;
		cnt_res  = sel_fill;
		ctl_a    = '{op: ROW_HOLD, key: idle_key};
		ctl_b    = '{op: ROW_HOLD, key: idle_key};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (func)
						FN_INSERT: begin
							out_load = 1'b1;
							if (sel_fill == CAP_FILL) begin
								st_res = ST_FULL;
							end else begin
								cnt_res = sel_fill + ONE_FILL;
								if (list_sel) begin
									ctl_b.op = ROW_INSERT;
									fill_b_d = cnt_res;
								end else begin
									ctl_a.op = ROW_INSERT;
									fill_a_d = cnt_res;
								end
							end
						end
						FN_DELETE: begin
							out_load = 1'b1;
							if (sel_fill == '0) begin
								st_res = ST_EMPTY;
							end else if (!sel_found) begin
								st_res = ST_MISSING;
							end else begin
								cnt_res = sel_fill - ONE_FILL;
								if (list_sel) begin
									ctl_b.op = ROW_DELETE;
									fill_b_d = cnt_res;
								end else begin
									ctl_a.op = ROW_DELETE;
									fill_a_d = cnt_res;
								end
							end
						end
						FN_MERGE: begin
							cnt_res = fill_a_q;
							if (fill_b_q == '0) begin
								out_load = 1'b1;
							end else begin
								state_d = S_MERGE;
								rem_d   = fill_b_q;
								mfull_d = 1'b0;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_MERGE: begin
				// head of B goes into A, unless A is full, while B rotates by one entry
				ctl_b.op  = ROW_ROTATE;
				ctl_a.key = to_upper(head_b);
				if (!full_now) begin
					ctl_a.op = ROW_INSERT;
					fill_a_d = fill_a_q + ONE_FILL;
				end
				mfull_d = mfull_q || full_now;
				rem_d   = rem_q - ONE_FILL;
				cnt_res = fill_a_d;
				if (rem_q == ONE_FILL) begin
					out_load = 1'b1;
					st_res   = mfull_d ? ST_FULL : ST_DONE;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign cnt_ext = 32'(cnt_res);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_a_q    <= '0;
			fill_b_q    <= '0;
			rem_q       <= '0;
			mfull_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_a_q <= fill_a_d;
			fill_b_q <= fill_b_d;
			rem_q    <= rem_d;
			mfull_q  <= mfull_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q     <= st_res;
			fill_count_q <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign fill_count = fill_count_q;

endmodule

[sv/obl_checker.sv]
// obl_checker: port-level assertions for the ordered byte list engine
// depends on obl_pkg; bound to ordered_byte_list_engine

module obl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] func,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [4:0] fill_count
);
	import obl_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_count))
		else $error("result item changed while stalled");

	// no new item taken while a result waits
	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while output stalled");

	// insert, delete and no-op items answer on the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func != FN_MERGE) |=> out_valid)
		else $error("missing result after insert, delete or no-op");

	// an empty report comes with an empty table
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> fill_count == '0)
		else $error("empty status with nonzero fill count");

endmodule

bind ordered_byte_list_engine obl_checker u_obl_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for ordered_byte_list_engine, driving insert, delete,
// merge and no-op items under random idling and long output hold-offs
// depends on obl_pkg and ordered_byte_list_engine

module tb;
	import obl_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int CLK_HALF    = 2;
	localparam int MAX_REPORTS = 10;

	// stimulus mix of an episode
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED
	} mix_t;

	typedef struct {
		status_t    st;
		logic [4:0] cnt;
	} answer_t;

	// mirror of both sorted tables plus the queue of answers still owed
	class byte_table_scoreboard;
		byte_t   entries [2][TABLE_DEPTH];
		int      counts [2];
		answer_t owed [$];
		int      errors;
		int      checked;
		int      op_seen [4];
		int      status_seen [4];

		function logic letter(byte_t c);
			return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
		endfunction

		function byte_t upcase(byte_t c);
			return ((c >= CH_LA) && (c <= CH_LZ)) ? byte_t'(c - CASE_OFFSET) : c;
		endfunction

		// place before the first entry that is not smaller
		function status_t place(int t, byte_t v);
			int pos;
			int i;
			byte_t u;
			if (counts[t] >= TABLE_DEPTH) return ST_FULL;
			u = upcase(v);
			pos = 0;
			while ((pos < counts[t]) && (entries[t][pos] < u)) pos++;
			for (i = counts[t]; i > pos; i--) entries[t][i] = entries[t][i-1];
			entries[t][pos] = u;
			counts[t]++;
			return ST_DONE;
		endfunction

		// remove the first equal entry, folding only when both are letters
		function status_t remove(int t, byte_t v);
			int pos;
			int i;
			byte_t u;
			if (counts[t] == 0) return ST_EMPTY;
			u = (letter(v) && letter(entries[t][0])) ? upcase(v) : v;
			pos = 0;
			while ((pos < counts[t]) && (entries[t][pos] < u)) pos++;
			if ((pos >= counts[t]) || (entries[t][pos] != u)) return ST_MISSING;
			for (i = pos; i + 1 < counts[t]; i++) entries[t][i] = entries[t][i+1];
			counts[t]--;
			return ST_DONE;
		endfunction

		function void note_item(logic [1:0] fn, logic sel, byte_t v);
			answer_t a;
			int k;
			int t;
			t = sel ? 1 : 0;
			a.st = ST_DONE;
			case (fn)
				FN_INSERT: begin
					a.st = place(t, v);
					a.cnt = 5'(counts[t]);
				end
				FN_DELETE: begin
					a.st = remove(t, v);
					a.cnt = 5'(counts[t]);
				end
				FN_MERGE: begin
					for (k = 0; k < counts[1]; k++) begin
						a.st = place(0, entries[1][k]);
						if (a.st != ST_DONE) break;
					end
					a.cnt = 5'(counts[0]);
				end
				default: begin
					a.cnt = 5'(counts[t]);
				end
			endcase
			op_seen[fn]++;
			status_seen[a.st]++;
			owed.push_back(a);
		endfunction

		function void check_item(status_t st, logic [4:0] cnt);
			answer_t a;
			checked++;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result %0d arrived with nothing owed: status %0d fill %0d",
						checked, st, cnt);
				return;
			end
			a = owed.pop_front();
			if ((st !== a.st) || (cnt !== a.cnt)) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("result %0d mismatch: status exp %0d got %0d, fill exp %0d got %0d",
						checked, a.st, st, a.cnt, cnt);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] func = FN_INSERT;
	logic       list_sel = 1'b0;
	logic [7:0] value = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [4:0] fill_count;

	byte_table_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	ordered_byte_list_engine #(
		.CAPACITY(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.list_sel(list_sel),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.fill_count(fill_count)
	);

	// clock
	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// overall time limit
	initial begin
		#(2_000_000);
		$display("FAILURE");
		$finish;
	end

	// receiver: random back-pressure, plus long hold-offs on request
	initial begin
		@(posedge arst_n);
		forever @(negedge clk) begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_request != 0) begin
				hold_request = 0;
				hold_left = 80;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// result check at each accepted output item
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_item(status, fill_count);
	end

	// offer one item from a falling edge, leave at the falling edge after acceptance
	task automatic send_item(input logic [1:0] fn, input logic sel, input byte_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		list_sel <= sel;
		value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_item(fn, sel, v);
		@(negedge clk);
	endtask

	function automatic byte_t pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 35) return byte_t'($urandom_range(255));
		if (r < 50) return byte_t'(CH_UA + $urandom_range(25));
		if (r < 65) return byte_t'(CH_LA + $urandom_range(25));
		if (r < 85) begin
			case ($urandom_range(9))
				0: return 8'h00;
				1: return 8'h01;
				2: return 8'h40;
				3: return 8'h5B;
				4: return 8'h60;
				5: return 8'h7B;
				6: return 8'h7F;
				7: return 8'h80;
				8: return 8'hFE;
				default: return 8'hFF;
			endcase
		end
		return byte_t'(8'h38 + $urandom_range(80));
	endfunction

	// one random item; deletes mostly aim at entries that are really there
	task automatic random_item(input mix_t mix);
		int r;
		int n;
		int ins_lim;
		int del_lim;
		logic [1:0] fn;
		logic sel;
		byte_t v;
		r = $urandom_range(99);
		sel = 1'($urandom_range(1));
		case (mix)
			MIX_FILL: begin
				ins_lim = 70;
				del_lim = 82;
			end
			MIX_DRAIN: begin
				ins_lim = 20;
				del_lim = 88;
			end
			default: begin
				ins_lim = 45;
				del_lim = 85;
			end
		endcase
		if (r < ins_lim) fn = FN_INSERT;
		else if (r < del_lim) fn = FN_DELETE;
		else if (r < 95) fn = FN_MERGE;
		else fn = FN_NOP;
		v = pick_byte();
		if (fn == FN_DELETE) begin
			n = sb.counts[sel];
			if ((n > 0) && ($urandom_range(99) < 65)) begin
				v = sb.entries[sel][$urandom_range(n - 1)];
				if ((v >= CH_UA) && (v <= CH_UZ) && ($urandom_range(1) == 1))
					v = v + CASE_OFFSET;
			end
		end
		send_item(fn, sel, v);
	endtask

	task automatic random_phase(input int items);
		int i;
		mix_t mix;
		mix = MIX_BALANCED;
		for (i = 0; i < items; i++) begin
			if ((i % 40) == 0) mix = mix_t'($urandom_range(2));
			if ((i == 20) || (i == items / 2)) hold_request = 1;
			random_item(mix);
		end
	endtask

	// stimulus
	initial begin
		int guard;
		sb = new;
		send_idle_pct = 17;
		recv_idle_pct = 81;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty tables, empty merge and the unused code
		send_item(FN_DELETE, 1'b0, 8'h00);
		send_item(FN_DELETE, 1'b1, 8'hFF);
		send_item(FN_MERGE, 1'b1, 8'hA5);
		send_item(FN_NOP, 1'b0, 8'h5A);
		send_item(FN_NOP, 1'b1, 8'hFF);
		// case folding on insert and the byte extremes
		send_item(FN_INSERT, 1'b0, CH_LA);
		send_item(FN_INSERT, 1'b0, CH_LZ);
		send_item(FN_INSERT, 1'b0, 8'hFF);
		send_item(FN_INSERT, 1'b0, 8'h00);
		// lower-case delete is not folded while the smallest entry is no letter
		send_item(FN_DELETE, 1'b0, CH_LA);
		send_item(FN_DELETE, 1'b0, 8'h00);
		// now the smallest entry is a letter, so the delete folds
		send_item(FN_DELETE, 1'b0, CH_LZ);
		send_item(FN_DELETE, 1'b0, 8'h42);
		// fill B a little and merge it into A
		send_item(FN_INSERT, 1'b1, 8'h80);
		send_item(FN_INSERT, 1'b1, 8'h71);
		send_item(FN_INSERT, 1'b1, 8'h7F);
		send_item(FN_INSERT, 1'b1, 8'h80);
		send_item(FN_MERGE, 1'b0, 8'h00);
		send_item(FN_DELETE, 1'b1, 8'hFE);
		send_item(FN_DELETE, 1'b1, 8'h71);
		send_item(FN_NOP, 1'b0, 8'h00);

		random_phase(540);
		send_idle_pct = 81;
		recv_idle_pct = 17;
		random_phase(545);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(545);
		in_valid <= 1'b0;

		// drain what is still owed, then let the bench idle before the report
		guard = 0;
		while ((sb.owed.size() != 0) && (guard < 5000)) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * TABLE_DEPTH) @(posedge clk);

		$display("run covered %0d items: %0d inserts, %0d deletes, %0d merges, %0d no-ops",
			sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3],
			sb.op_seen[FN_INSERT], sb.op_seen[FN_DELETE], sb.op_seen[FN_MERGE],
			sb.op_seen[FN_NOP]);
		$display("outcomes: %0d done, %0d empty, %0d not found, %0d full; %0d errors",
			sb.status_seen[ST_DONE], sb.status_seen[ST_EMPTY],
			sb.status_seen[ST_MISSING], sb.status_seen[ST_FULL], sb.errors);
		if ((sb.errors == 0) && (sb.owed.size() == 0)) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
